>>> rtl/bal_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array list package
// Item types, command codes, status codes and controller/datapath interface
// structures shared by the list engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bal_pkg;

  localparam int DATA_W    = 32;
  localparam int POS_W     = 6;
  localparam int MODE_W    = 3;
  localparam int CNT_OUT_W = 6;
  localparam int STATUS_W  = 2;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SORT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_OUT_W-1:0]     entry_count;
    logic                     is_full;
    logic                     is_empty;
    logic [CNT_OUT_W-1:0]     removed_count;
    logic [STATUS_W-1:0]      status;
  } out_t;

  typedef enum logic [3:0] {
    UOP_NOP,
    UOP_APPEND,
    UOP_SET_FULL,
    UOP_SET_RANGE,
    UOP_SORT_INIT,
    UOP_SORT_CUR,
    UOP_SORT_CMP,
    UOP_SORT_WB,
    UOP_INS_INIT,
    UOP_INS_SHIFT,
    UOP_INS_PUT,
    UOP_REM_INIT,
    UOP_REM_STEP,
    UOP_REM_END,
    UOP_READ_ISSUE,
    UOP_READ_TAKE
  } uop_t;

  typedef struct packed {
    logic capture;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              full;
    logic              cnt_zero;
    logic              cnt_lt2;
    logic              pos_gt_cnt;
    logic              pos_eq_cnt;
    logic              pos_lt_cnt;
    logic              scan_end;
    logic              pass_last;
    logic              at_pos;
  } stat_t;

endpackage

`default_nettype wire

>>> rtl/bounded_array_list_engine.sv
// Sequencing: append, insert at the end, empty remove, short sort, failed commands and unused
//   codes go from dispatch straight to the result strobe; read, insert at p below n entries,
//   remove over n > 0 entries and sort of n >= 2 entries pass through their own states first.
// Throughput: busy is released in the cycle after the strobe; the single list memory read
//   port, one entry per cycle, bounds every command that scans the list.
// Reset: synchronous active-low rst_n empties the list; entry contents are left undefined.
// ----------------------------------------------------------------------------
// Bounded array list engine
// Fixed-capacity list of signed values with append, sort, insert, remove-all
// and read commands; one result item per command item.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_engine #(
  parameter int CAPACITY = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  bal_pkg::in_t  in_item,
  output logic          busy,
  output logic          out_valid,
  output bal_pkg::out_t out_item
);

  bal_pkg::cmd_t  cmd;
  bal_pkg::stat_t stat;

  bal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  bal_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/bal_ctrl.sv
// ----------------------------------------------------------------------------
// Bounded array list controller
// One-hot state machine that sequences each command item through the
// datapath micro-operations and strobes the result.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output bal_pkg::cmd_t  cmd,
  input  bal_pkg::stat_t stat
);

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b000_0000_0001,
    ST_DISPATCH  = 11'b000_0000_0010,
    ST_SORT_CUR  = 11'b000_0000_0100,
    ST_SORT_CMP  = 11'b000_0000_1000,
    ST_SORT_WB   = 11'b000_0001_0000,
    ST_INS_SHIFT = 11'b000_0010_0000,
    ST_INS_PUT   = 11'b000_0100_0000,
    ST_REM_STEP  = 11'b000_1000_0000,
    ST_REM_END   = 11'b001_0000_0000,
    ST_READ_WAIT = 11'b010_0000_0000,
    ST_DONE      = 11'b100_0000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.uop     = bal_pkg::UOP_NOP;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        state_nxt = ST_DONE;
        case (stat.mode)
          bal_pkg::MODE_APPEND: begin
            cmd.uop = stat.full ? bal_pkg::UOP_SET_FULL : bal_pkg::UOP_APPEND;
          end
          bal_pkg::MODE_SORT: begin
            if (!stat.cnt_lt2) begin
              cmd.uop   = bal_pkg::UOP_SORT_INIT;
              state_nxt = ST_SORT_CUR;
            end
          end
          bal_pkg::MODE_INSERT: begin
            if (stat.full) begin
              cmd.uop = bal_pkg::UOP_SET_FULL;
            end else if (stat.pos_gt_cnt) begin
              cmd.uop = bal_pkg::UOP_SET_RANGE;
            end else if (stat.pos_eq_cnt) begin
              cmd.uop = bal_pkg::UOP_INS_PUT;
            end else begin
              cmd.uop   = bal_pkg::UOP_INS_INIT;
              state_nxt = ST_INS_SHIFT;
            end
          end
          bal_pkg::MODE_REMOVE: begin
            if (!stat.cnt_zero) begin
              cmd.uop   = bal_pkg::UOP_REM_INIT;
              state_nxt = ST_REM_STEP;
            end
          end
          bal_pkg::MODE_READ: begin
            if (stat.pos_lt_cnt) begin
              cmd.uop   = bal_pkg::UOP_READ_ISSUE;
              state_nxt = ST_READ_WAIT;
            end else begin
              cmd.uop = bal_pkg::UOP_SET_RANGE;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SORT_CUR: begin
        cmd.uop   = bal_pkg::UOP_SORT_CUR;
        state_nxt = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        cmd.uop = bal_pkg::UOP_SORT_CMP;
        if (stat.scan_end) begin
          state_nxt = ST_SORT_WB;
        end
      end
      ST_SORT_WB: begin
        cmd.uop   = bal_pkg::UOP_SORT_WB;
        state_nxt = stat.pass_last ? ST_DONE : ST_SORT_CUR;
      end
      ST_INS_SHIFT: begin
        cmd.uop = bal_pkg::UOP_INS_SHIFT;
        if (stat.at_pos) begin
          state_nxt = ST_INS_PUT;
        end
      end
      ST_INS_PUT: begin
        cmd.uop   = bal_pkg::UOP_INS_PUT;
        state_nxt = ST_DONE;
      end
      ST_REM_STEP: begin
        cmd.uop = bal_pkg::UOP_REM_STEP;
        if (stat.scan_end) begin
          state_nxt = ST_REM_END;
        end
      end
      ST_REM_END: begin
        cmd.uop   = bal_pkg::UOP_REM_END;
        state_nxt = ST_DONE;
      end
      ST_READ_WAIT: begin
        cmd.uop   = bal_pkg::UOP_READ_TAKE;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_DONE);

`ifndef SYNTHESIS
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_idle_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("engine still busy after result");

  a_busy_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule

`default_nettype wire

>>> rtl/bal_dp.sv
// ----------------------------------------------------------------------------
// Bounded array list datapath
// List memory, count, scan indices and result registers; carries out one
// micro-operation per cycle as commanded by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module bal_dp #(
  parameter int CAPACITY = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bal_pkg::in_t   in_item,
  input  bal_pkg::cmd_t  cmd,
  output bal_pkg::stat_t stat,
  output bal_pkg::out_t  out_item
);

  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CMP_W     = (CNT_W > bal_pkg::POS_W) ? CNT_W : bal_pkg::POS_W;
  localparam int DW        = bal_pkg::DATA_W;
  localparam int OUT_CNT_W = bal_pkg::CNT_OUT_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic signed [DW-1:0] mem [CAPACITY];

  logic [bal_pkg::MODE_W-1:0]   mode_r, mode_nxt;
  logic [bal_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic signed [DW-1:0]         val_r, val_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic [CNT_W-1:0]             i_r, i_nxt;
  logic [CNT_W-1:0]             j_r, j_nxt;
  logic signed [DW-1:0]         cur_r, cur_nxt;
  logic signed [DW-1:0]         rdata_r;
  logic signed [DW-1:0]         rd_val_r, rd_val_nxt;
  logic [CNT_W-1:0]             removed_r, removed_nxt;
  logic [bal_pkg::STATUS_W-1:0] status_r, status_nxt;

  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic signed [DW-1:0] wdata;
  logic [IDX_W-1:0]     raddr;

  logic [CNT_W-1:0] j_inc, j_dec, i_inc, i_inc2, cnt_inc, cnt_dec;
  logic [CMP_W-1:0] pos_ext, cnt_ext;

  assign j_inc   = j_r + CNT_W'(1);
  assign j_dec   = j_r - CNT_W'(1);
  assign i_inc   = i_r + CNT_W'(1);
  assign i_inc2  = i_r + CNT_W'(2);
  assign cnt_inc = count_r + CNT_W'(1);
  assign cnt_dec = count_r - CNT_W'(1);
  assign pos_ext = CMP_W'(pos_r);
  assign cnt_ext = CMP_W'(count_r);

  always_comb begin
    stat.mode       = mode_r;
    stat.full       = (count_r == CAP_CNT);
    stat.cnt_zero   = (count_r == '0);
    stat.cnt_lt2    = (count_r < CNT_W'(2));
    stat.pos_gt_cnt = (pos_ext > cnt_ext);
    stat.pos_eq_cnt = (pos_ext == cnt_ext);
    stat.pos_lt_cnt = (pos_ext < cnt_ext);
    stat.scan_end   = (j_r == count_r);
    stat.pass_last  = (i_inc2 >= count_r);
    stat.at_pos     = (CMP_W'(j_r) == pos_ext);
  end

  always_comb begin
    mode_nxt    = mode_r;
    pos_nxt     = pos_r;
    val_nxt     = val_r;
    count_nxt   = count_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cur_nxt     = cur_r;
    rd_val_nxt  = rd_val_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    we          = 1'b0;
    waddr       = '0;
    wdata       = val_r;
    raddr       = '0;

    if (cmd.capture) begin
      mode_nxt    = in_item.mode;
      pos_nxt     = in_item.position;
      val_nxt     = in_item.value;
      rd_val_nxt  = '0;
      removed_nxt = '0;
      status_nxt  = bal_pkg::STATUS_OK;
    end

    case (cmd.uop)
      bal_pkg::UOP_APPEND: begin
        we        = 1'b1;
        waddr     = count_r[IDX_W-1:0];
        wdata     = val_r;
        count_nxt = cnt_inc;
      end
      bal_pkg::UOP_SET_FULL: begin
        status_nxt = bal_pkg::STATUS_FULL;
      end
      bal_pkg::UOP_SET_RANGE: begin
        status_nxt = bal_pkg::STATUS_RANGE;
      end
      bal_pkg::UOP_SORT_INIT: begin
        raddr = '0;
        i_nxt = '0;
        j_nxt = CNT_W'(1);
      end
      bal_pkg::UOP_SORT_CUR: begin
        cur_nxt = rdata_r;
        raddr   = j_r[IDX_W-1:0];
        j_nxt   = j_inc;
      end
      bal_pkg::UOP_SORT_CMP: begin
        if (rdata_r < cur_r) begin
          we      = 1'b1;
          waddr   = j_dec[IDX_W-1:0];
          wdata   = cur_r;
          cur_nxt = rdata_r;
        end
        raddr = j_r[IDX_W-1:0];
        j_nxt = j_inc;
      end
      bal_pkg::UOP_SORT_WB: begin
        we    = 1'b1;
        waddr = i_r[IDX_W-1:0];
        wdata = cur_r;
        raddr = i_inc[IDX_W-1:0];
        i_nxt = i_inc;
        j_nxt = i_inc2;
      end
      bal_pkg::UOP_INS_INIT: begin
        raddr = cnt_dec[IDX_W-1:0];
        j_nxt = cnt_dec;
      end
      bal_pkg::UOP_INS_SHIFT: begin
        we    = 1'b1;
        waddr = j_inc[IDX_W-1:0];
        wdata = rdata_r;
        raddr = j_dec[IDX_W-1:0];
        j_nxt = j_dec;
      end
      bal_pkg::UOP_INS_PUT: begin
        we        = 1'b1;
        waddr     = IDX_W'(pos_r);
        wdata     = val_r;
        count_nxt = cnt_inc;
      end
      bal_pkg::UOP_REM_INIT: begin
        raddr = '0;
        i_nxt = '0;
        j_nxt = CNT_W'(1);
      end
      bal_pkg::UOP_REM_STEP: begin
        if (rdata_r != val_r) begin
          we    = 1'b1;
          waddr = i_r[IDX_W-1:0];
          wdata = rdata_r;
          i_nxt = i_inc;
        end
        raddr = j_r[IDX_W-1:0];
        j_nxt = j_inc;
      end
      bal_pkg::UOP_REM_END: begin
        removed_nxt = count_r - i_r;
        count_nxt   = i_r;
      end
      bal_pkg::UOP_READ_ISSUE: begin
        raddr = IDX_W'(pos_r);
      end
      bal_pkg::UOP_READ_TAKE: begin
        rd_val_nxt = rdata_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r    <= mode_nxt;
    pos_r     <= pos_nxt;
    val_r     <= val_nxt;
    i_r       <= i_nxt;
    j_r       <= j_nxt;
    cur_r     <= cur_nxt;
    rd_val_r  <= rd_val_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

  always_comb begin
    out_item.read_value    = rd_val_r;
    out_item.entry_count   = OUT_CNT_W'(count_r);
    out_item.is_full       = (count_r == CAP_CNT);
    out_item.is_empty      = (count_r == '0);
    out_item.removed_count = OUT_CNT_W'(removed_r);
    out_item.status        = status_r;
  end

`ifndef SYNTHESIS
  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count exceeds capacity");

  a_compact_trails_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.uop == bal_pkg::UOP_REM_STEP) |-> (i_r < j_r))
    else $error("compaction write index overtook read index");
`endif

endmodule

`default_nettype wire
